// ===== sv/block_map_allocator_top_defines.svh =====
// assertion macros shared by the allocator checker
`ifndef BLOCK_MAP_ALLOCATOR_TOP_DEFINES_SVH
`define BLOCK_MAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define BMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, sampled on clk, off during rst
`define BMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== sv/bma_pkg.sv =====
// types, codes and defaults shared by the block map allocator
`timescale 1ns / 1ps

package bma_pkg;

  // default geometry
  localparam int MEM_BLOCKS_DEF      = 1024;
  localparam int RESERVED_BLOCKS_DEF = 32;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_TERM  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED  = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
  localparam logic [1:0] ST_TERMINATED = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  // one request
  typedef struct packed {
    logic        cmd;
    logic [9:0]  request_size;
    logic [15:0] target_id;
  } req_t;

  // one result
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] assigned_id;
    logic [9:0]  first_block;
    logic [10:0] free_blocks;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic load;
    logic scan_en;
    logic report;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic scan_done;
  } sts_t;

endpackage

// ===== sv/bma_ctrl.sv =====
// sequencing state machine of the block map allocator
`timescale 1ns / 1ps

module bma_ctrl import bma_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output ctl_t ctl,
  input  sts_t sts
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register, map clear runs first after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_REPORT;
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    ctl.clear_en = (state == S_CLEAR);
    ctl.load     = (state == S_IDLE) && start;
    ctl.scan_en  = (state == S_SCAN);
    ctl.report   = (state == S_REPORT);
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== sv/bma_datapath.sv =====
// block map memories, scan pipeline, counters and result register
`timescale 1ns / 1ps

module bma_datapath import bma_pkg::*; #(
  parameter int MEM_BLOCKS      = MEM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  output sts_t sts,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int AW = $clog2(MEM_BLOCKS);
  localparam int CW = $clog2(MEM_BLOCKS + 1);
  localparam int KW = (CW > 10) ? CW : 10;
  localparam int FW = AW + 10;
  localparam int GW = CW + 11;
  localparam logic [AW-1:0] LAST_ADDR  = AW'(MEM_BLOCKS - 1);
  localparam logic [AW-1:0] FIRST_ADDR = AW'(RESERVED_BLOCKS);

  // block map storage
  logic        used_mem  [MEM_BLOCKS];
  logic [15:0] owner_mem [MEM_BLOCKS];
  logic        used_rd;
  logic [15:0] owner_rd;

  // latched request
  logic        cmd_q;
  logic [9:0]  size_q;
  logic [15:0] id_q;
  logic        refused;

  // scan state
  logic [AW-1:0] addr;
  logic          issued_all;
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [9:0]    placed;
  logic          found;
  logic [9:0]    first_q;

  logic [CW-1:0] free_count;
  logic [15:0]   next_process;

  logic          is_alloc;
  logic          alloc_stop;
  logic          issue;
  logic          claim;
  logic          release_blk;
  logic [FW-1:0] s1_addr_ext;
  logic [GW-1:0] free_ext;

  assign is_alloc    = (cmd_q == CMD_ALLOC);
  assign alloc_stop  = is_alloc && (refused || (placed == size_q));
  assign issue       = ctl.scan_en && !issued_all && !alloc_stop;
  assign claim       = s1_valid && is_alloc && !refused && (placed != size_q) && !used_rd;
  assign release_blk = s1_valid && !is_alloc && used_rd && (owner_rd == id_q);
  assign s1_addr_ext = FW'(s1_addr);
  assign free_ext    = GW'(free_count);

  assign sts.clear_last = ctl.clear_en && (addr == LAST_ADDR);
  assign sts.scan_done  = alloc_stop || (issued_all && !s1_valid);

  // used-bit memory: clear sweep or scan write, registered read
  always_ff @(posedge clk) begin
    if (ctl.clear_en) begin
      used_mem[addr] <= (addr < FIRST_ADDR);
    end else if (claim || release_blk) begin
      used_mem[s1_addr] <= claim;
    end
    used_rd <= used_mem[addr];
  end

  // owner tag memory, written on claim only
  always_ff @(posedge clk) begin
    if (claim) begin
      owner_mem[s1_addr] <= id_q;
    end
    owner_rd <= owner_mem[addr];
  end

  // request latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= request.cmd;
      size_q  <= request.request_size;
      id_q    <= (request.cmd == CMD_ALLOC) ? next_process : request.target_id;
      refused <= (KW'(free_count) < KW'(request.request_size));
    end
  end

  // address counter and read stage tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      issued_all <= 1'b0;
      s1_valid   <= 1'b0;
    end else if (ctl.load) begin
      addr       <= FIRST_ADDR;
      issued_all <= 1'b0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (ctl.clear_en || issue) begin
        addr <= addr + AW'(1);
      end
      if (issue && (addr == LAST_ADDR)) begin
        issued_all <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr;
  end

  // per-request claim and release bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      placed  <= '0;
      found   <= 1'b0;
      first_q <= '0;
    end else begin
      if (claim) begin
        placed <= placed + 10'd1;
        if (placed == 10'd0) first_q <= s1_addr_ext[9:0];
      end
      if (release_blk) found <= 1'b1;
    end
  end

  // free count and process counter
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= CW'(MEM_BLOCKS - RESERVED_BLOCKS);
      next_process <= '0;
    end else begin
      if (claim) begin
        free_count <= free_count - CW'(1);
      end else if (release_blk) begin
        free_count <= free_count + CW'(1);
      end
      if (ctl.load && (request.cmd == CMD_ALLOC)) begin
        next_process <= next_process + 16'd1;
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.report;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      result.assigned_id <= id_q;
      result.free_blocks <= free_ext[10:0];
      if (is_alloc) begin
        result.status      <= refused ? ST_NO_MEMORY : ST_ALLOCATED;
        result.first_block <= refused ? 10'd0 : first_q;
      end else begin
        result.status      <= found ? ST_TERMINATED : ST_NOT_FOUND;
        result.first_block <= 10'd0;
      end
    end
  end

endmodule

// ===== sv/block_map_allocator_top.sv =====
// top level of the first-fit block map allocator
//
//   channel   signals                  handshake
//   request   start, busy, request     taken when start is high and busy is low
//   result    done, result             valid for the one cycle done is high
//
// after reset a clearing pass writes the used-bit map, one block a cycle,
// over all MEM_BLOCKS blocks with busy high
// each request scans the map one block per cycle through a registered read,
// bounded by the memory port: a terminate scans every block from RESERVED_BLOCKS
// on, an allocate stops after its last claimed block, and a refused or empty
// allocate scans no block
// the result register drives done for one cycle; the receiver cannot stall
`timescale 1ns / 1ps

module block_map_allocator_top import bma_pkg::*; #(
  parameter int MEM_BLOCKS      = MEM_BLOCKS_DEF,
  parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  ctl_t ctl;
  sts_t sts;

  // sequencer
  bma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  // block map and counters
  bma_datapath #(
    .MEM_BLOCKS      (MEM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .sts     (sts),
    .request (request),
    .done    (done),
    .result  (result)
  );

endmodule

// ===== sv/bma_checker.sv =====
// port-level checks on the block map allocator, bound to the top level
`timescale 1ns / 1ps
`include "block_map_allocator_top_defines.svh"

module bma_checker import bma_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  // a result only appears once the block is free again
  `BMA_ASSERT_NOW(a_done_idle, done, !busy)

  // an accepted request keeps the block busy next cycle
  `BMA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // the result strobe lasts one cycle
  `BMA_ASSERT_NEXT(a_done_pulse, done, !done)

  // only a granted allocate reports a first block
  `BMA_ASSERT_NOW(a_first_zero, done && (result.status != ST_ALLOCATED), result.first_block == 10'd0)

endmodule

bind block_map_allocator_top bma_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the first-fit block map allocator
`timescale 1ns / 1ps

module tb_top import bma_pkg::*;;

  localparam int MEM = MEM_BLOCKS_DEF;
  localparam int RES = RESERVED_BLOCKS_DEF;
  localparam int RANDOM_ITEMS = 580;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  // shadow of the block map, predicts every result
  class alloc_scoreboard;
    bit          used [MEM];
    logic [15:0] owner [MEM];
    int unsigned free_cnt;
    logic [15:0] next_pid;
    rsp_t        expected_q [$];
    logic [15:0] live_ids [$];
    int unsigned errors;
    int unsigned reported;
    int unsigned n_alloc, n_refused, n_term, n_unknown;

    function new();
      for (int i = 0; i < MEM; i++) begin
        used[i]  = (i < RES);
        owner[i] = 16'h0;
      end
      free_cnt  = MEM - RES;
      next_pid  = 16'h0;
      errors    = 0;
      reported  = 0;
      n_alloc   = 0;
      n_refused = 0;
      n_term    = 0;
      n_unknown = 0;
    endfunction

    // apply one accepted request to the shadow map and queue its result
    function void note_request(req_t r);
      rsp_t        e;
      int unsigned placed;
      bit          found;
      logic [15:0] pid;
      e      = '0;
      placed = 0;
      found  = 1'b0;
      if (r.cmd == CMD_ALLOC) begin
        pid      = next_pid;
        next_pid = next_pid + 16'd1;
        n_alloc++;
        e.assigned_id = pid;
        if (free_cnt < r.request_size) begin
          e.status = ST_NO_MEMORY;
          n_refused++;
        end else begin
          e.status = ST_ALLOCATED;
          // lowest free blocks, holes allowed
          for (int i = RES; i < MEM && placed < r.request_size; i++) begin
            if (!used[i]) begin
              if (placed == 0) e.first_block = 10'(i);
              used[i]  = 1'b1;
              owner[i] = pid;
              placed++;
            end
          end
          free_cnt -= placed;
          if (placed != 0) live_ids.push_back(pid);
        end
      end else begin
        n_term++;
        e.assigned_id = r.target_id;
        // every tagged block above the system area goes back
        for (int i = RES; i < MEM; i++) begin
          if (used[i] && owner[i] == r.target_id) begin
            used[i] = 1'b0;
            free_cnt++;
            found = 1'b1;
          end
        end
        e.status = found ? ST_TERMINATED : ST_NOT_FOUND;
        if (!found) n_unknown++;
        for (int k = live_ids.size() - 1; k >= 0; k--) begin
          if (live_ids[k] == r.target_id) live_ids.delete(k);
        end
      end
      e.free_blocks = 11'(free_cnt);
      expected_q.push_back(e);
    endfunction

    // compare one result against the oldest prediction
    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: status %0d id %0d first %0d free %0d",
                   got.status, got.assigned_id, got.first_block, got.free_blocks);
        end
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.assigned_id !== e.assigned_id ||
          got.first_block !== e.first_block || got.free_blocks !== e.free_blocks) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected status %0d id %0d first %0d free %0d",
                   e.status, e.assigned_id, e.first_block, e.free_blocks);
          $display("          actual   status %0d id %0d first %0d free %0d",
                   got.status, got.assigned_id, got.first_block, got.free_blocks);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;

  alloc_scoreboard sb = new();
  int unsigned cycle_count = 0;

  block_map_allocator_top #(
    .MEM_BLOCKS      (MEM),
    .RESERVED_BLOCKS (RES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // result monitor, values seen just before the edge
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(result);
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  function automatic req_t alloc_req(int unsigned size);
    req_t r;
    r.cmd          = CMD_ALLOC;
    r.request_size = 10'(size);
    r.target_id    = 16'($urandom);
    return r;
  endfunction

  function automatic req_t term_req(logic [15:0] pid);
    req_t r;
    r.cmd          = CMD_TERM;
    r.request_size = 10'($urandom);
    r.target_id    = pid;
    return r;
  endfunction

  // send one request after an idle gap, return once it is taken
  task automatic issue(req_t r, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(r);
  endtask

  // hold off until every queued result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned gap;
    int unsigned burst_left;
    int unsigned sel;
    int unsigned size;
    rst         = 1'b1;
    start       = 1'b0;
    request     = '0;
    burst_left  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, single, oversize, holes, full map, unknown ids
    issue(alloc_req(0), 0);
    issue(alloc_req(1), $urandom_range(0, 3));
    issue(alloc_req(1023), $urandom_range(0, 3));
    issue(alloc_req(5), $urandom_range(0, 3));
    issue(term_req(16'd1), $urandom_range(0, 3));
    issue(alloc_req(3), $urandom_range(0, 3));
    issue(term_req(16'd0), $urandom_range(0, 3));
    issue(term_req(16'hFFFF), $urandom_range(0, 3));
    issue(alloc_req(sb.free_cnt), $urandom_range(0, 3));
    issue(alloc_req(1), $urandom_range(0, 3));
    issue(alloc_req(0), $urandom_range(0, 3));
    issue(term_req(16'd2), $urandom_range(0, 3));
    while (sb.live_ids.size() != 0) issue(term_req(sb.live_ids[0]), $urandom_range(0, 3));
    issue(alloc_req(sb.free_cnt), $urandom_range(0, 3));
    issue(term_req(sb.live_ids[0]), $urandom_range(0, 3));
    issue(alloc_req(1023), $urandom_range(0, 3));
    issue(term_req(16'($urandom)), $urandom_range(0, 3));
    drain();

    // random mix, mostly small allocates and terminates of live processes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0 && $urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 30);
      if (burst_left != 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, 3);
      end
      if ($urandom_range(0, 99) == 0) drain();
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 9))
          0:       size = $urandom_range(0, 1023);
          1, 2:    size = $urandom_range(17, 200);
          default: size = $urandom_range(1, 16);
        endcase
        issue(alloc_req(size), gap);
      end else if (sel < 85 && sb.live_ids.size() != 0) begin
        issue(term_req(sb.live_ids[$urandom_range(0, sb.live_ids.size() - 1)]), gap);
      end else begin
        issue(term_req(16'($urandom)), gap);
      end
    end
    drain();

    // wind down
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (MEM + 16) @(posedge clk);
    if (sb.pending() != 0) sb.errors += sb.pending();

    $display("tb_top: covered %0d allocates (%0d refused) and %0d terminates (%0d unknown)",
             sb.n_alloc, sb.n_refused, sb.n_term, sb.n_unknown);
    $display("tb_top: holes, full map and back-to-back requests seen, %0d result errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
